FILE: sv/avr_pkg.sv
`default_nettype none

package avr_pkg;

  // Axis selector codes
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // Quadrant codes of the quarter-turn step
  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;

  // Micro-rotation count and datapath widths
  localparam int ITERS = 30;
  // Pre-scaled coordinates reach about 2^39.5 in magnitude over the iterations
  localparam int DW    = 42;
  // Residual angle, 2^32 per full turn, stays within +/- 2^29
  localparam int ZW    = 33;

  // Cycles from an accepted request to its result strobe
  localparam int LATENCY = ITERS + 4;

  // 1/K in 32 fractional bits
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  // atan(2^-i) in turns, 2^32 per full turn
  localparam logic [31:0] ATAN_TURNS [ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        angle;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
  } rsp_t;

  // One slot of the micro-rotation pipeline
  typedef struct packed {
    logic                 vld;
    logic [1:0]           axis;
    logic signed [31:0]   c;
    logic signed [31:0]   ra;
    logic signed [31:0]   rb;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [ZW-1:0] z;
  } stage_t;

endpackage

`default_nettype wire

FILE: sv/axis_vector_rotator.sv
`default_nettype none

// Rotates a Q16.16 vector about the x, y or z axis by a 16-bit binary angle
// (65536 per turn); axis code 3 passes the vector through. A request is taken
// on any cycle with start high and busy low, so one vector per clock is
// sustained; busy is high only while rst is held. Each result appears on rsp
// for exactly one cycle with done high, in request order. The receiver cannot
// stall the block and must take every result in its strobe cycle. The
// pipeline registers are the gain multiply, its rounding, the quarter-turn
// step, 30 micro-rotation stages of one step each, and the output round and
// saturate stage.
module axis_vector_rotator import avr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  localparam logic signed [32:0] INV_GAIN_S = {1'b0, INV_GAIN};
  localparam logic [63:0]        RND_PRE    = 64'h0000_0000_0080_0000;
  localparam logic [DW:0]        RND_OUT    = (DW+1)'(128);
  localparam logic [15:0]        HALF_QUAD  = 16'h2000;

  typedef struct packed {
    logic               vld;
    logic [1:0]         axis;
    logic [1:0]         quad;
    logic signed [13:0] resid;
    logic signed [31:0] c;
    logic signed [31:0] ra;
    logic signed [31:0] rb;
    logic signed [63:0] pa;
    logic signed [63:0] pb;
  } mul_t;

  typedef struct packed {
    logic                 vld;
    logic [1:0]           axis;
    logic [1:0]           quad;
    logic signed [13:0]   resid;
    logic signed [31:0]   c;
    logic signed [31:0]   ra;
    logic signed [31:0]   rb;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
  } scl_t;

  mul_t   mul;
  mul_t   mul_next;
  scl_t   scl;
  scl_t   scl_next;
  stage_t cin;
  stage_t cin_next;
  stage_t cout;
  rsp_t   rsp_next;

  logic signed [31:0] sel_a;
  logic signed [31:0] sel_b;
  logic signed [31:0] sel_c;
  logic [15:0]        ang_sum;
  logic signed [64:0] prod_a;
  logic signed [64:0] prod_b;
  logic [63:0]        rnd_a;
  logic [63:0]        rnd_b;
  logic signed [31:0] fin_a;
  logic signed [31:0] fin_b;
  logic               accept;

  // Round off eight guard bits and clamp to the Q16.16 range
  function automatic logic signed [31:0] round_sat(input logic signed [DW-1:0] v);
    logic [DW:0]   t;
    logic [DW-8:0] s;
    t = {v[DW-1], v} + RND_OUT;
    s = t[DW:8];
    if ((&s[DW-8:31]) || !(|s[DW-8:31])) begin
      return s[31:0];
    end else if (s[DW-8]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  assign busy   = rst;
  assign accept = start && !busy;

  // Pick the rotation plane and apply the inverse gain
  always_comb begin
    case (req.action)
      AXIS_X: begin
        sel_a = req.y_in;
        sel_b = req.z_in;
        sel_c = req.x_in;
      end
      AXIS_Y: begin
        sel_a = req.z_in;
        sel_b = req.x_in;
        sel_c = req.y_in;
      end
      default: begin
        sel_a = req.x_in;
        sel_b = req.y_in;
        sel_c = req.z_in;
      end
    endcase
    ang_sum        = req.angle + HALF_QUAD;
    prod_a         = sel_a * INV_GAIN_S;
    prod_b         = sel_b * INV_GAIN_S;
    mul_next.vld   = accept;
    mul_next.axis  = req.action;
    mul_next.quad  = ang_sum[15:14];
    mul_next.resid = {~ang_sum[13], ang_sum[12:0]};
    mul_next.c     = sel_c;
    mul_next.ra    = sel_a;
    mul_next.rb    = sel_b;
    mul_next.pa    = prod_a[63:0];
    mul_next.pb    = prod_b[63:0];
  end

  // Round the scaled products to 24 fractional bits of the input scale
  always_comb begin
    rnd_a          = mul.pa + RND_PRE;
    rnd_b          = mul.pb + RND_PRE;
    scl_next.vld   = mul.vld;
    scl_next.axis  = mul.axis;
    scl_next.quad  = mul.quad;
    scl_next.resid = mul.resid;
    scl_next.c     = mul.c;
    scl_next.ra    = mul.ra;
    scl_next.rb    = mul.rb;
    scl_next.a     = DW'($signed(rnd_a[63:24]));
    scl_next.b     = DW'($signed(rnd_b[63:24]));
  end

  // Take out whole quarter turns, leave the residual for the micro-rotations
  always_comb begin
    cin_next.vld  = scl.vld;
    cin_next.axis = scl.axis;
    cin_next.c    = scl.c;
    cin_next.ra   = scl.ra;
    cin_next.rb   = scl.rb;
    cin_next.z    = ZW'($signed({scl.resid, 16'b0}));
    case (scl.quad)
      QUAD_90: begin
        cin_next.a = -scl.b;
        cin_next.b = scl.a;
      end
      QUAD_180: begin
        cin_next.a = -scl.a;
        cin_next.b = -scl.b;
      end
      QUAD_270: begin
        cin_next.a = scl.b;
        cin_next.b = -scl.a;
      end
      default: begin
        cin_next.a = scl.a;
        cin_next.b = scl.b;
      end
    endcase
  end

  // Advance the front stages; clear them on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      mul <= '0;
      scl <= '0;
      cin <= '0;
    end else begin
      mul <= mul_next;
      scl <= scl_next;
      cin <= cin_next;
    end
  end

  avr_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .src (cin),
    .dst (cout)
  );

  // Put the rotated pair back on its axes; axis code 3 passes the input through
  always_comb begin
    fin_a = round_sat(cout.a);
    fin_b = round_sat(cout.b);
    case (cout.axis)
      AXIS_X: begin
        rsp_next.x_out = cout.c;
        rsp_next.y_out = fin_a;
        rsp_next.z_out = fin_b;
      end
      AXIS_Y: begin
        rsp_next.x_out = fin_b;
        rsp_next.y_out = cout.c;
        rsp_next.z_out = fin_a;
      end
      AXIS_Z: begin
        rsp_next.x_out = fin_a;
        rsp_next.y_out = fin_b;
        rsp_next.z_out = cout.c;
      end
      default: begin
        rsp_next.x_out = cout.ra;
        rsp_next.y_out = cout.rb;
        rsp_next.z_out = cout.c;
      end
    endcase
  end

  // Hold the result for its strobe cycle
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cout.vld;
    end
  end

  // Every request comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result strobe missing after request");

  // The coordinate on the x axis passes through a rotation about x
  a_axis_x_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == AXIS_X) |-> ##LATENCY (rsp.x_out == $past(req.x_in, LATENCY)))
    else $error("x coordinate changed by rotation about x");

  // Axis code three leaves the whole vector alone
  a_passthru: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == AXIS_NONE) |-> ##LATENCY
      (rsp.x_out == $past(req.x_in, LATENCY) && rsp.y_out == $past(req.y_in, LATENCY) &&
       rsp.z_out == $past(req.z_in, LATENCY)))
    else $error("pass-through request altered");

  // Reset flushes the pipeline
  a_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

endmodule

`default_nettype wire

FILE: sv/avr_cordic.sv
`default_nettype none

module avr_cordic import avr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire stage_t src,
  output stage_t      dst
);

  stage_t pipe [ITERS];

  for (genvar i = 0; i < ITERS; i++) begin : g_stage
    stage_t               prv;
    stage_t               nxt;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [ZW-1:0] step;

    if (i == 0) begin : g_first
      assign prv = src;
    end else begin : g_rest
      assign prv = pipe[i-1];
    end

    // Rotate toward zero residual angle by atan(2^-i)
    always_comb begin
      dx   = prv.b >>> i;
      dy   = prv.a >>> i;
      step = ZW'(ATAN_TURNS[i]);
      nxt  = prv;
      if (!prv.z[ZW-1]) begin
        nxt.a = prv.a - dx;
        nxt.b = prv.b + dy;
        nxt.z = prv.z - step;
      end else begin
        nxt.a = prv.a + dx;
        nxt.b = prv.b - dy;
        nxt.z = prv.z + step;
      end
    end

    // Advance one slot; clear it on reset
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[i] <= '0;
      end else begin
        pipe[i] <= nxt;
      end
    end
  end

  assign dst = pipe[ITERS-1];

endmodule

`default_nettype wire

FILE: test/avr_rotation_check.sv
`timescale 1ns / 100ps

module avr_rotation_check import avr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic busy,
  input  req_t      req,
  input  wire logic done,
  input  rsp_t      rsp,
  output int        fails,
  output int        pending,
  output int        compared
);

  // 1/K with 32 fractional bits
  localparam longint INV_K_Q32 = 64'sh9B74EDA8;
  localparam int     MICRO_STEPS = 30;
  // Room for every request in flight, with margin
  localparam int     DUE_DEPTH = 64;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn
  localparam longint ATAN_TURN [MICRO_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
  };

  rsp_t due_mem [DUE_DEPTH];
  int   due_wr = 0;
  int   due_rd = 0;
  int   mismatch_cnt = 0;
  int   result_cnt = 0;

  // Round off the 8 guard bits and clamp to the Q16.16 range
  function automatic logic [31:0] sat_q16(longint v);
    longint r;
    r = (v + 64'sd128) >>> 8;
    if (r > 64'sd2147483647)
      return 32'h7FFF_FFFF;
    if (r < -64'sd2147483648)
      return 32'h8000_0000;
    return r[31:0];
  endfunction

  // Rotate the pair (a, b) counterclockwise by a binary angle
  function automatic void rotate_plane(input logic [15:0] angle, inout longint a,
                                       inout longint b);
    longint t;
    longint dx;
    longint dy;
    longint resid;
    int     s;
    logic [1:0] quad;
    s = int'(angle) + 8192;
    quad = s[15:14];
    a = (a * INV_K_Q32 + (64'sd1 <<< 23)) >>> 24;
    b = (b * INV_K_Q32 + (64'sd1 <<< 23)) >>> 24;
    // take out whole quarter turns first
    case (quad)
      QUAD_90: begin
        t = a; a = -b; b = t;
      end
      QUAD_180: begin
        a = -a; b = -b;
      end
      QUAD_270: begin
        t = a; a = b; b = -t;
      end
      default: ;
    endcase
    resid = longint'(s % 16384 - 8192) * 64'sd65536;
    // drive the residual angle to zero
    for (int i = 0; i < MICRO_STEPS; i++) begin
      dx = b >>> i;
      dy = a >>> i;
      if (resid >= 0) begin
        a -= dx; b += dy; resid -= ATAN_TURN[i];
      end else begin
        a += dx; b -= dy; resid += ATAN_TURN[i];
      end
    end
  endfunction

  function automatic rsp_t rotated_vector(req_t r);
    rsp_t   v;
    longint a;
    longint b;
    v.x_out = r.x_in;
    v.y_out = r.y_in;
    v.z_out = r.z_in;
    case (r.action)
      AXIS_X: begin
        a = longint'(r.y_in); b = longint'(r.z_in);
        rotate_plane(r.angle, a, b);
        v.y_out = sat_q16(a); v.z_out = sat_q16(b);
      end
      AXIS_Y: begin
        a = longint'(r.z_in); b = longint'(r.x_in);
        rotate_plane(r.angle, a, b);
        v.z_out = sat_q16(a); v.x_out = sat_q16(b);
      end
      AXIS_Z: begin
        a = longint'(r.x_in); b = longint'(r.y_in);
        rotate_plane(r.angle, a, b);
        v.x_out = sat_q16(a); v.y_out = sat_q16(b);
      end
      default: ;
    endcase
    return v;
  endfunction

  // Compare each strobed result against the oldest request, then queue new ones
  always @(posedge clk) begin
    rsp_t        want;
    logic [31:0] exp_f [3];
    logic [31:0] got_f [3];
    if (!rst) begin
      if (done) begin
        if (due_wr == due_rd) begin
          mismatch_cnt++;
          $display("%0t: result with no request pending: expected none, got %h",
                   $time, rsp);
        end else begin
          want = due_mem[due_rd % DUE_DEPTH];
          due_rd++;
          exp_f = '{want.x_out, want.y_out, want.z_out};
          got_f = '{rsp.x_out, rsp.y_out, rsp.z_out};
          for (int k = 0; k < 3; k++) begin
            if (got_f[k] !== exp_f[k]) begin
              mismatch_cnt++;
              $display("%0t: %s_out mismatch: expected %h, got %h", $time,
                       k == 0 ? "x" : (k == 1 ? "y" : "z"), exp_f[k], got_f[k]);
            end
          end
          result_cnt++;
        end
      end
      if (start && !busy) begin
        if (due_wr - due_rd == DUE_DEPTH) begin
          mismatch_cnt++;
          $display("%0t: too many requests in flight: expected at most %0d, got %0d",
                   $time, DUE_DEPTH, due_wr - due_rd + 1);
          due_rd++;
        end
        due_mem[due_wr % DUE_DEPTH] = rotated_vector(req);
        due_wr++;
      end
    end
    fails <= mismatch_cnt;
    pending <= due_wr - due_rd;
    compared <= result_cnt;
  end

endmodule

FILE: test/tb_axis_vector_rotator.sv
`timescale 1ns / 100ps

module tb_axis_vector_rotator;
  import avr_pkg::*;

  localparam int RANDOM_VECTORS = 1760;
  localparam int PHASE_LEN = RANDOM_VECTORS / 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  int fails;
  int pending;
  int compared;
  int sent = 0;
  int idle_pct [4] = '{0, 56, 0, 17};

  axis_vector_rotator DUT (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  avr_rotation_check u_check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .fails   (fails),
    .pending (pending),
    .compared(compared)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic req_t vec(logic [1:0] act, logic [15:0] ang, logic [31:0] x,
                               logic [31:0] y, logic [31:0] z);
    req_t r;
    r.action = act;
    r.angle = ang;
    r.x_in = x;
    r.y_in = y;
    r.z_in = z;
    return r;
  endfunction

  // Mix full-range, small, near-limit and scaled-down coordinates
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 2097151) - 32'd1048576;
      3: return 32'h7FFF_FFFF - $urandom_range(0, 255);
      4: return 32'h8000_0000 + $urandom_range(0, 255);
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  // Favor octant boundaries now and then; the quarter step changes at every second one
  function automatic logic [15:0] rand_angle();
    logic [31:0] a;
    if ($urandom_range(0, 3) == 0)
      a = $urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2;
    else
      a = $urandom;
    return a[15:0];
  endfunction

  function automatic logic [1:0] rand_axis();
    int k;
    k = $urandom_range(0, 11);
    if (k == 0)
      return AXIS_NONE;
    if (k < 4)
      return AXIS_X;
    if (k < 8)
      return AXIS_Y;
    return AXIS_Z;
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_vector(req_t r);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Drop start for the given gap with junk on the request bus
  task automatic idle_gap(int cycles);
    logic [159:0] junk;
    junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
    start <= 1'b0;
    req <= junk[$bits(req_t)-1:0];
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    req_t corner [$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners: quarter turns, octant edges, limits, pass-through and saturation
    corner = '{
      vec(AXIS_X, 16'd0,     32'h0001_0000, 32'h0002_0000, 32'h0003_0000),
      vec(AXIS_Y, 16'd16384, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000),
      vec(AXIS_Z, 16'd32768, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000),
      vec(AXIS_X, 16'd49152, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000),
      vec(AXIS_Z, 16'd8192,  32'h0001_0000, 32'h0000_0000, 32'h0000_0000),
      vec(AXIS_Z, 16'd8191,  32'h0001_0000, 32'h0000_0000, 32'h0000_0000),
      vec(AXIS_Y, 16'd65535, 32'h0004_0000, 32'hFFFF_0000, 32'h0000_8000),
      vec(AXIS_X, 16'd24576, 32'h0000_0001, 32'h0010_0000, 32'hFFF0_0000),
      vec(AXIS_NONE, 16'd12345, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF),
      vec(AXIS_Z, 16'd8192,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000),
      vec(AXIS_Z, 16'd8192,  32'h8000_0000, 32'h8000_0000, 32'h0000_0000),
      vec(AXIS_X, 16'd40960, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000),
      vec(AXIS_Y, 16'd0,     32'h8000_0000, 32'h0000_0000, 32'h8000_0000),
      vec(AXIS_Z, 16'd0,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000),
      vec(AXIS_Z, 16'd4096,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000),
      vec(AXIS_Y, 16'd57344, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      vec(AXIS_X, 16'd1,     32'h0000_0001, 32'h0000_0001, 32'h0000_0001),
      vec(AXIS_NONE, 16'd0,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000),
      vec(AXIS_Z, 16'd65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
      vec(AXIS_Y, 16'd32768, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000),
      vec(AXIS_X, 16'd8192,  32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555)
    };
    foreach (corner[i])
      send_vector(corner[i]);

    // random vectors in four pacing phases
    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_vector(vec(rand_axis(), rand_angle(), rand_coord(), rand_coord(),
                        rand_coord()));
        if ($urandom_range(0, 99) < idle_pct[p])
          idle_gap($urandom_range(1, 3));
      end
    end
    start <= 1'b0;

    // drain, then watch a while for stray strobes
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Sent %0d vectors: corner cases, then random ones over four pacing phases",
             sent);
    $display("Compared %0d rotated vectors, %0d mismatches", compared, fails);
    if (fails == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
